// ===== sv/bfsam_pkg.sv =====
// Shared widths, codes and reset values for the breadth-first search block.
`default_nettype none

package bfsam_pkg;

   // Field widths fixed by the interface.
   localparam int VERTEX_W = 6;
   localparam int COUNT_W  = 7;
   localparam int MODE_W   = 2;

   // Default size of the vertex set.
   localparam int DEFAULT_VERTICES = 64;

   // Command codes carried on req_mode.
   localparam logic [MODE_W-1:0] MODE_ADD_EDGE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WALK     = 2'd2;

   // Register interface.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_VERTEX_COUNT = 1'b0;
   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

endpackage

`default_nettype wire

// ===== sv/bfsam_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none

module bfsam_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/bfsam_csr.sv =====
// Configuration register file holding the vertex count for walks.
`default_nettype none

module bfsam_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [bfsam_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [bfsam_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [bfsam_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                      csr_pready,
   output logic      [bfsam_pkg::COUNT_W-1:0]        vertex_count
);

   localparam int CNT_W  = bfsam_pkg::COUNT_W;
   localparam int DATA_W = bfsam_pkg::CSR_DATA_W;

   logic [CNT_W-1:0] vertex_count_ff;
   logic [CNT_W-1:0] vertex_count_in;
   logic             wr_beat;
   logic             sel_count;

   assign wr_beat   = csr_psel & csr_penable & csr_pwrite;
   assign sel_count = (csr_paddr[2] == bfsam_pkg::CSR_IDX_VERTEX_COUNT);

   // Register update on the access phase of a write beat.
   always_comb begin
      vertex_count_in = vertex_count_ff;
      if (wr_beat && sel_count) begin
         vertex_count_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= bfsam_pkg::VERTEX_COUNT_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   // Read data; unmapped addresses read as zero.
   always_comb begin
      csr_prdata = '0;
      if (sel_count) begin
         csr_prdata = DATA_W'(vertex_count_ff);
      end
   end

   assign csr_pready   = 1'b1;
   assign vertex_count = vertex_count_ff;

endmodule

`default_nettype wire

// ===== sv/bfs_adjacency_matrix_top.sv =====
// Top level of the breadth-first search engine over an adjacency bit matrix.
//
// Commands are taken with start while busy is low. A valid edge add keeps the block
// busy while it updates the first row and then the second (only the one row for a
// self loop); a matrix clear and a bad start do not make the block busy. A walk
// goes through pop, fetch, load and scan states for each visited vertex, as the
// queue and row memories have registered reads and are fetched one after the
// other, and the scan queues one neighbor per cycle through the enqueue port.
// Results appear for exactly one cycle on rsp_valid, and the receiver has no way
// to hold them off. Within a walk they never come in consecutive cycles, but the
// error beat of a bad start can come in the cycle after any earlier beat. The
// last beat of a walk carries rsp_last. A matrix clear resets per-row valid flags,
// so it needs no sweep.
`default_nettype none

module bfs_adjacency_matrix_top #(
   parameter int VERTICES = bfsam_pkg::DEFAULT_VERTICES
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Command channel
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [bfsam_pkg::MODE_W-1:0]         req_mode,
   input  wire logic [bfsam_pkg::VERTEX_W-1:0]       req_first_vertex,
   input  wire logic [bfsam_pkg::VERTEX_W-1:0]       req_second_vertex,
   // Result channel
   output logic                                      rsp_valid,
   output logic      [bfsam_pkg::VERTEX_W-1:0]       rsp_vertex,
   output logic                                      rsp_last,
   output logic                                      rsp_error,
   // Configuration port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [bfsam_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [bfsam_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [bfsam_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                      csr_pready
);

   localparam int VTX_W = bfsam_pkg::VERTEX_W;
   localparam int CNT_W = bfsam_pkg::COUNT_W;
   localparam int AW    = $clog2(VERTICES);
   localparam int CW    = $clog2(VERTICES + 1);
   localparam logic [CNT_W-1:0] VERT_CNT = CNT_W'(VERTICES);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EDGE_A = 7'b0000010,
      ST_EDGE_B = 7'b0000100,
      ST_POP    = 7'b0001000,
      ST_FETCH  = 7'b0010000,
      ST_LOAD   = 7'b0100000,
      ST_SCAN   = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [VERTICES-1:0]   row_valid_ff, row_valid_in;
   logic [VERTICES-1:0]   visited_ff, visited_in;
   logic [VERTICES-1:0]   cand_ff, cand_in;
   logic [AW-1:0]         edge_a_ff, edge_a_in;
   logic [AW-1:0]         edge_b_ff, edge_b_in;
   logic [VTX_W-1:0]      cur_ff, cur_in;
   logic [CW-1:0]         head_ff, head_in;
   logic [CW-1:0]         tail_ff, tail_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VTX_W-1:0]      rsp_vertex_ff, rsp_vertex_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_error_ff, rsp_error_in;

   logic [CNT_W-1:0]      vertex_count;
   logic [CNT_W-1:0]      eff_count;
   logic [VERTICES-1:0]   cnt_mask;
   logic [VERTICES-1:0]   low_bit;
   logic [AW-1:0]         low_idx;
   logic                  accept;

   logic                  adj_wr_en;
   logic [AW-1:0]         adj_wr_addr;
   logic [VERTICES-1:0]   adj_wr_data;
   logic [AW-1:0]         adj_rd_addr;
   logic [VERTICES-1:0]   adj_rd_data;

   logic                  q_wr_en;
   logic [AW-1:0]         q_wr_addr;
   logic [VTX_W-1:0]      q_wr_data;
   logic [AW-1:0]         q_rd_addr;
   logic [VTX_W-1:0]      q_rd_data;

   // Register file.
   bfsam_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .vertex_count (vertex_count)
   );

   // Adjacency rows, one word of neighbor bits per vertex.
   bfsam_ram #(
      .WIDTH (VERTICES),
      .DEPTH (VERTICES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   // Vertex queue of the walk.
   bfsam_ram #(
      .WIDTH (VTX_W),
      .DEPTH (VERTICES)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   // A count above the vertex set acts as the full set.
   assign eff_count = (vertex_count > VERT_CNT) ? VERT_CNT : vertex_count;

   // Neighbors at or above the count are ignored by a walk.
   always_comb begin
      for (int i = 0; i < VERTICES; i++) begin
         cnt_mask[i] = (CNT_W'(i) < eff_count);
      end
   end

   // Lowest pending neighbor, isolated and then encoded.
   assign low_bit = cand_ff & ((~cand_ff) + VERTICES'(1));

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < VERTICES; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | AW'(i);
         end
      end
   end

   assign accept = start & (state_ff == ST_IDLE);

   // Sequencer: edge updates, matrix clears, walk steps and result generation.
   always_comb begin
      state_in      = state_ff;
      row_valid_in  = row_valid_ff;
      visited_in    = visited_ff;
      cand_in       = cand_ff;
      edge_a_in     = edge_a_ff;
      edge_b_in     = edge_b_ff;
      cur_in        = cur_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rsp_valid_in  = 1'b0;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_error_in  = rsp_error_ff;
      adj_wr_en     = 1'b0;
      adj_wr_addr   = edge_a_ff;
      adj_wr_data   = '0;
      adj_rd_addr   = '0;
      q_wr_en       = 1'b0;
      q_wr_addr     = '0;
      q_wr_data     = req_first_vertex;
      q_rd_addr     = head_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  bfsam_pkg::MODE_ADD_EDGE: begin
                     if (({1'b0, req_first_vertex} < VERT_CNT) &&
                         ({1'b0, req_second_vertex} < VERT_CNT)) begin
                        adj_rd_addr = req_first_vertex[AW-1:0];
                        edge_a_in   = req_first_vertex[AW-1:0];
                        edge_b_in   = req_second_vertex[AW-1:0];
                        state_in    = ST_EDGE_A;
                     end
                  end
                  bfsam_pkg::MODE_CLEAR: begin
                     row_valid_in = '0;
                  end
                  bfsam_pkg::MODE_WALK: begin
                     if ({1'b0, req_first_vertex} < eff_count) begin
                        // Seed the queue with the start vertex, marked visited.
                        q_wr_en    = 1'b1;
                        q_wr_addr  = '0;
                        q_wr_data  = req_first_vertex;
                        visited_in = VERTICES'(1) << req_first_vertex;
                        head_in    = '0;
                        tail_in    = CW'(1);
                        state_in   = ST_POP;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_vertex_in = '0;
                        rsp_last_in   = 1'b1;
                        rsp_error_in  = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_EDGE_A: begin
            adj_wr_en   = 1'b1;
            adj_wr_addr = edge_a_ff;
            adj_wr_data = (row_valid_ff[edge_a_ff] ? adj_rd_data : '0) |
                          (VERTICES'(1) << edge_b_ff);
            row_valid_in[edge_a_ff] = 1'b1;
            if (edge_a_ff == edge_b_ff) begin
               state_in = ST_IDLE;
            end else begin
               adj_rd_addr = edge_b_ff;
               state_in    = ST_EDGE_B;
            end
         end

         ST_EDGE_B: begin
            adj_wr_en   = 1'b1;
            adj_wr_addr = edge_b_ff;
            adj_wr_data = (row_valid_ff[edge_b_ff] ? adj_rd_data : '0) |
                          (VERTICES'(1) << edge_a_ff);
            row_valid_in[edge_b_ff] = 1'b1;
            state_in = ST_IDLE;
         end

         ST_POP: begin
            q_rd_addr = head_ff[AW-1:0];
            head_in   = head_ff + CW'(1);
            state_in  = ST_FETCH;
         end

         ST_FETCH: begin
            cur_in      = q_rd_data;
            adj_rd_addr = q_rd_data[AW-1:0];
            state_in    = ST_LOAD;
         end

         ST_LOAD: begin
            // Unvisited neighbors below the count still to be queued.
            cand_in = (row_valid_ff[cur_ff[AW-1:0]] ? adj_rd_data : '0) &
                      cnt_mask & ~visited_ff;
            state_in = ST_SCAN;
         end

         ST_SCAN: begin
            if (cand_ff != '0) begin
               // Queue one neighbor per cycle in ascending order.
               q_wr_en    = 1'b1;
               q_wr_addr  = tail_ff[AW-1:0];
               q_wr_data  = VTX_W'(low_idx);
               tail_in    = tail_ff + CW'(1);
               visited_in = visited_ff | low_bit;
               cand_in    = cand_ff & ~low_bit;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = cur_ff;
               rsp_last_in   = (head_ff == tail_ff);
               rsp_error_in  = 1'b0;
               state_in      = (head_ff == tail_ff) ? ST_IDLE : ST_POP;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_valid_ff <= '0;
         visited_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         visited_ff   <= visited_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cand_ff       <= cand_in;
      edge_a_ff     <= edge_a_in;
      edge_b_ff     <= edge_b_in;
      cur_ff        <= cur_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_error  = rsp_error_ff;

endmodule

`default_nettype wire
